// ----- hdl/jsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and constants for the JPEG scan counter.
// ----------------------------------------------------------------------------
package jsc_pkg;

    localparam int SCAN_W  = 16;
    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_START0     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START1     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_EXPECT_FF  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_MARKER     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_HI     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LO     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SKIP       = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ENTROPY    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ENTROPY_FF = 4'd8;
    localparam logic [PHASE_W-1:0] PH_DONE       = 4'd9;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_STUFF  = 8'h00;

    typedef struct packed {
        logic              valid;
        logic              well_formed;
        logic [SCAN_W-1:0] scan_count;
    } jsc_verdict_t;

endpackage

// ----- hdl/jsc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_parser
// Marker-structure state machine; consumes one byte per step and flags a
// verdict with the saturated scan count.
// ----------------------------------------------------------------------------
module jsc_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output jsc_pkg::jsc_verdict_t verdict
);

    logic [jsc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_BITS-1:0]       scans_reg, scans_next;
    logic [7:0]                  len_hi_reg, len_hi_next;
    logic [15:0]                 skip_reg, skip_next;
    logic                        is_scan_reg, is_scan_next;

    logic                        code_good, code_bad, code_alone, code_rst;
    logic [15:0]                 seg_len;
    logic [15:0]                 skip_dec;
    logic [COUNT_BITS-1:0]       scans_inc;
    logic [jsc_pkg::PHASE_W-1:0] end_phase;
    logic [COUNT_BITS-1:0]       end_scans;
    logic                        hit_good, hit_bad, report;
    logic [COUNT_BITS+jsc_pkg::SCAN_W-1:0] scans_wide;
    logic [jsc_pkg::SCAN_W-1:0]  scans_out;

    assign code_rst   = (data_byte >= jsc_pkg::MK_RST0) && (data_byte <= jsc_pkg::MK_RST7);
    assign code_good  = (data_byte == jsc_pkg::MK_EOI);
    assign code_bad   = (data_byte == jsc_pkg::MK_SOI) || (data_byte == jsc_pkg::MK_STUFF);
    assign code_alone = code_rst || (data_byte == jsc_pkg::MK_TEM);

    assign seg_len   = {len_hi_reg, data_byte};
    assign skip_dec  = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;
    assign scans_inc = (scans_reg == {COUNT_BITS{1'b1}}) ? scans_reg
                                                         : scans_reg + 1'b1;
    // segment end: scans go to entropy data
    assign end_phase = is_scan_reg ? jsc_pkg::PH_ENTROPY : jsc_pkg::PH_EXPECT_FF;
    assign end_scans = is_scan_reg ? scans_inc : scans_reg;

    assign scans_wide = {{jsc_pkg::SCAN_W{1'b0}}, scans_reg};
    assign scans_out  = (scans_wide[COUNT_BITS+jsc_pkg::SCAN_W-1:jsc_pkg::SCAN_W] != '0)
                      ? {jsc_pkg::SCAN_W{1'b1}}
                      : scans_wide[jsc_pkg::SCAN_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        scans_next   = scans_reg;
        len_hi_next  = len_hi_reg;
        skip_next    = skip_reg;
        is_scan_next = is_scan_reg;
        hit_good     = 1'b0;
        hit_bad      = 1'b0;

        unique case (phase_reg)
            jsc_pkg::PH_START0:
            begin
                if (data_byte != jsc_pkg::MK_PREFIX)
                    hit_bad = 1'b1;
                else
                    phase_next = jsc_pkg::PH_START1;
            end
            jsc_pkg::PH_START1:
            begin
                if (data_byte != jsc_pkg::MK_SOI)
                    hit_bad = 1'b1;
                else
                    phase_next = jsc_pkg::PH_EXPECT_FF;
            end
            jsc_pkg::PH_EXPECT_FF:
            begin
                if (data_byte != jsc_pkg::MK_PREFIX)
                    hit_bad = 1'b1;
                else
                    phase_next = jsc_pkg::PH_MARKER;
            end
            jsc_pkg::PH_MARKER, jsc_pkg::PH_ENTROPY_FF:
            begin
                priority if (data_byte == jsc_pkg::MK_PREFIX)
                    phase_next = phase_reg;
                else if (phase_reg == jsc_pkg::PH_ENTROPY_FF
                         && (data_byte == jsc_pkg::MK_STUFF || code_rst))
                    phase_next = jsc_pkg::PH_ENTROPY;
                else if (code_good)
                    hit_good = 1'b1;
                else if (code_bad)
                    hit_bad = 1'b1;
                else if (code_alone)
                    phase_next = jsc_pkg::PH_EXPECT_FF;
                else
                begin
                    is_scan_next = (data_byte == jsc_pkg::MK_SOS);
                    phase_next   = jsc_pkg::PH_LEN_HI;
                end
            end
            jsc_pkg::PH_LEN_HI:
            begin
                len_hi_next = data_byte;
                phase_next  = jsc_pkg::PH_LEN_LO;
            end
            jsc_pkg::PH_LEN_LO:
            begin
                if (seg_len[15:1] == 15'd0)
                    hit_bad = 1'b1;
                else
                begin
                    skip_next = seg_len - 16'd2;
                    if (seg_len == 16'd2)
                    begin
                        phase_next = end_phase;
                        scans_next = end_scans;
                    end
                    else
                        phase_next = jsc_pkg::PH_SKIP;
                end
            end
            jsc_pkg::PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = end_phase;
                    scans_next = end_scans;
                end
            end
            jsc_pkg::PH_ENTROPY:
            begin
                if (data_byte == jsc_pkg::MK_PREFIX)
                    phase_next = jsc_pkg::PH_ENTROPY_FF;
            end
            jsc_pkg::PH_DONE:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                hit_bad = 1'b1;
            end
        endcase

        // early end counts as malformed
        report = (phase_reg != jsc_pkg::PH_DONE) && (hit_good || hit_bad || last_byte);

        if (last_byte)
        begin
            phase_next   = jsc_pkg::PH_START0;
            scans_next   = '0;
            len_hi_next  = 8'd0;
            skip_next    = 16'd0;
            is_scan_next = 1'b0;
        end
        else if (report)
            phase_next = jsc_pkg::PH_DONE;
    end

    always_comb
    begin
        verdict.valid       = step && report;
        verdict.well_formed = hit_good;
        verdict.scan_count  = hit_good ? scans_out : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jsc_pkg::PH_START0;
            scans_reg   <= '0;
            len_hi_reg  <= 8'd0;
            skip_reg    <= 16'd0;
            is_scan_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            scans_reg   <= scans_next;
            len_hi_reg  <= len_hi_next;
            skip_reg    <= skip_next;
            is_scan_reg <= is_scan_next;
        end
    end

endmodule

// ----- hdl/jpeg_scan_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_scan_counter
// Streaming JPEG marker checker; reports well-formedness and scan count.
// ----------------------------------------------------------------------------
// Takes one file byte per word; a new word is accepted every cycle unless
// the input register is full and the output register is stalled. A byte
// lands in the input register, the marker state machine consumes it once
// the output register can advance, and any verdict goes to the output register.
// Throughput is one byte per cycle while the output is not stalled. At
// most one verdict is issued per file; bytes after it are dropped through
// the byte flagged with tlast, and the following byte starts a new file.
module jpeg_scan_counter #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] scan_count
    output logic        m_axis_tuser    // well_formed
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_data_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           out_count_reg;
    logic                  out_good_reg;
    logic                  advance, accept, step;
    jsc_pkg::jsc_verdict_t verdict;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = verdict.valid ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    jsc_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (verdict.valid)
        begin
            out_count_reg <= verdict.scan_count;
            out_good_reg  <= verdict.well_formed;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_good_reg;

endmodule

// ----- hdl/jsc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks for the JPEG scan counter, bound to the top level.
// ----------------------------------------------------------------------------
module jsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input word changed while stalled");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // malformed verdicts carry a zero count
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("malformed verdict with nonzero count");

    // input backpressure only when the output register is blocked
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind jpeg_scan_counter jsc_checker u_jsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
